@@ design/mrlcp_pkg.sv @@
// Shared types and constants for the Modbus RTU load-cell poller.
// No dependencies.
package mrlcp_pkg;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_TARE = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_TARE = 2'd2;

  localparam logic [2:0] REG_ADDR    = 3'd0;
  localparam logic [2:0] REG_DATA    = 3'd1;
  localparam logic [2:0] REG_TRIG    = 3'd2;
  localparam logic [2:0] REG_TCMD    = 3'd3;
  localparam logic [2:0] REG_RTMO    = 3'd4;
  localparam logic [2:0] REG_POLL    = 3'd5;
  localparam logic [2:0] REG_SETTLE  = 3'd6;
  localparam logic [2:0] REG_HEALTH  = 3'd7;

  localparam logic [7:0]  FUNC_READ  = 8'd3;
  localparam logic [7:0]  FUNC_WRITE = 8'd6;
  localparam logic [7:0]  READ_BYTES = 8'd4;
  localparam logic [15:0] READ_COUNT = 16'd2;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [3:0]  WIN_DEPTH  = 4'd9;
  localparam logic [3:0]  READ_LEN   = 4'd9;
  localparam logic [3:0]  WRITE_LEN  = 4'd8;

  // CRC unit command / status
  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic       init;
  } crc_cmd_t;

  typedef struct packed {
    logic        busy;
    logic [15:0] crc;
  } crc_sts_t;

endpackage

@@ design/mrlcp_crc.sv @@
// Bit-serial CRC-16/Modbus unit: hashes one byte a bit at a time.
// Depends on mrlcp_pkg.
module mrlcp_crc
  import mrlcp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  crc_cmd_t cmd,
  output crc_sts_t sts
);

  logic [15:0] crc_r, crc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  always_comb begin
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    if (cmd.init) begin
      crc_nxt = CRC_INIT;
    end else if (cmd.start) begin
      crc_nxt = crc_r ^ {8'd0, cmd.data};
      cnt_nxt = 4'd8;
    end else if (cnt_r != 4'd0) begin
      // shift one bit
      crc_nxt = crc_r[0] ? ((crc_r >> 1) ^ CRC_POLY) : (crc_r >> 1);
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
      crc_r <= CRC_INIT;
    end else begin
      cnt_r <= cnt_nxt;
      crc_r <= crc_nxt;
    end
  end

  assign sts.busy = (cnt_r != 4'd0);
  assign sts.crc  = crc_r;

endmodule

@@ design/modbus_rtu_load_cell_poller_unit.sv @@
// Top level of the Modbus RTU load-cell poller: sequencer, window, timers, output stage.
// Depends on mrlcp_pkg and mrlcp_crc.
//
// Usage: the input stream carries one transaction per event: a received byte,
// a 1 ms tick or a tare request (in_tuser = opcode, in_tdata = byte). Each
// transaction produces either one status transaction or eight frame bytes on
// the output stream; out_tlast marks the final one. Status fields repeat on
// every output transaction of one input.
// Processing: a byte item checks the receive window with the shared bit-serial
// CRC unit, one window byte at a time, for a read response or a tare echo; a
// byte may try more than one window position. A sent frame is hashed with the
// same unit before its eight output transactions.
// Items are handled one at a time; in_tready is low while an item is at work.
// Reset (synchronous, rst_n low) restores register defaults, clears the
// exchange state and timers; a poll is due on the first tick.
// A stalled receiver (out_tready low) holds the current output transaction
// and the sequencer waits; nothing is lost.
module modbus_rtu_load_cell_poller_unit
  import mrlcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] tx_byte, [39:8] weight, [47:40] zero
  output logic [6:0]  out_tuser,  // [0] tx_valid, [1] sample_new, [2] tare_done,
                                  // [3] tare_accepted, [4] healthy, [6:5] busy_kind
  output logic        out_tlast
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_CRC   = 7'b0000100,
    ST_WAIT  = 7'b0001000,
    ST_JUDGE = 7'b0010000,
    ST_FRAME = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state_r;

  // configuration
  logic [7:0]  dev_addr_r;
  logic [15:0] data_reg_r, trig_reg_r, tare_cmd_r, rsp_tmo_r, poll_int_r, settle_r, health_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 8'd1;
      data_reg_r <= 16'd0;
      trig_reg_r <= 16'd0;
      tare_cmd_r <= 16'd1;
      rsp_tmo_r  <= 16'd100;
      poll_int_r <= 16'd50;
      settle_r   <= 16'd500;
      health_r   <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ADDR:   dev_addr_r <= cfg_wdata[7:0];
        REG_DATA:   data_reg_r <= cfg_wdata;
        REG_TRIG:   trig_reg_r <= cfg_wdata;
        REG_TCMD:   tare_cmd_r <= cfg_wdata;
        REG_RTMO:   rsp_tmo_r  <= cfg_wdata;
        REG_POLL:   poll_int_r <= cfg_wdata;
        REG_SETTLE: settle_r   <= cfg_wdata;
        REG_HEALTH: health_r   <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // exchange state
  logic [1:0]  pend_r;
  logic        tare_wait_r;
  logic [7:0]  win_r [WIN_DEPTH];
  logic [3:0]  fill_r;
  logic [15:0] since_req_r, until_poll_r, since_rd_r;
  logic        have_rd_r;
  logic [31:0] value_r;

  // per-item work
  logic [7:0]  frame_r [8];
  logic [3:0]  idx_r;     // byte index into window or frame
  logic [3:0]  len_r;     // bytes to hash
  logic        sent_r, sample_r, tdone_r, acc_r;
  logic [2:0]  ocnt_r;
  logic        crc_for_frame_r;

  crc_cmd_t crc_cmd;
  crc_sts_t crc_sts;

  mrlcp_crc u_crc (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (crc_cmd),
    .sts  (crc_sts)
  );

  logic in_acc, out_acc;
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign in_tready = (state_r == ST_IDLE);

  // byte fed to CRC
  logic [7:0] crc_byte;
  always_comb begin
    crc_byte = crc_for_frame_r ? frame_r[idx_r[2:0]] : win_r[idx_r];
    crc_cmd.init  = 1'b0;
    crc_cmd.start = 1'b0;
    crc_cmd.data  = crc_byte;
    if (state_r == ST_CHECK || (state_r == ST_FRAME && !sent_r)) crc_cmd.init = 1'b1;
    if (state_r == ST_CRC) crc_cmd.start = 1'b1;
  end

  // field match of the window for the pending kind
  logic fields_ok;
  logic [15:0] got_crc;
  always_comb begin
    if (pend_r == KIND_READ) begin
      fields_ok = win_r[0] == dev_addr_r && win_r[1] == FUNC_READ && win_r[2] == READ_BYTES;
      got_crc   = {win_r[8], win_r[7]};
    end else begin
      fields_ok = win_r[0] == dev_addr_r && win_r[1] == FUNC_WRITE &&
                  {win_r[2], win_r[3]} == trig_reg_r && {win_r[4], win_r[5]} == tare_cmd_r;
      got_crc   = {win_r[7], win_r[6]};
    end
  end

  logic [3:0] need;
  assign need = (pend_r == KIND_READ) ? READ_LEN : WRITE_LEN;
  logic [15:0] tick_req;
  assign tick_req = (since_req_r != 16'hFFFF) ? since_req_r + 16'd1 : since_req_r;

  logic [7:0] op_byte;
  assign op_byte = in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_r       <= KIND_NONE;
      tare_wait_r  <= 1'b0;
      fill_r       <= 4'd0;
      since_req_r  <= 16'd0;
      until_poll_r <= 16'd0;
      since_rd_r   <= 16'd0;
      have_rd_r    <= 1'b0;
      value_r      <= 32'd0;
      sent_r       <= 1'b0;
      sample_r     <= 1'b0;
      tdone_r      <= 1'b0;
      acc_r        <= 1'b0;
      ocnt_r       <= 3'd0;
      idx_r        <= 4'd0;
      len_r        <= 4'd0;
      crc_for_frame_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            sent_r <= 1'b0; sample_r <= 1'b0; tdone_r <= 1'b0; acc_r <= 1'b0;
            ocnt_r <= 3'd0;
            state_r <= ST_OUT;
            case (in_tuser)
              OP_BYTE: begin
                if (pend_r == KIND_NONE) begin
                  fill_r <= 4'd0;
                end else begin
                  // append byte, restart window when full
                  if (fill_r >= WIN_DEPTH) begin
                    win_r[0] <= op_byte;
                    fill_r   <= 4'd1;
                  end else begin
                    win_r[fill_r] <= op_byte;
                    fill_r <= fill_r + 4'd1;
                    if (fill_r + 4'd1 >= need) state_r <= ST_CHECK;
                  end
                end
              end
              OP_TICK: begin
                since_req_r <= tick_req;
                if (since_rd_r != 16'hFFFF) since_rd_r <= since_rd_r + 16'd1;
                if (pend_r != KIND_NONE && !(tick_req > rsp_tmo_r)) begin
                  if (until_poll_r != 16'd0) until_poll_r <= until_poll_r - 16'd1;
                end else begin
                  if (pend_r != KIND_NONE) begin
                    pend_r <= KIND_NONE;
                    fill_r <= 4'd0;
                  end
                  if (tare_wait_r) begin
                    tare_wait_r <= 1'b0;
                    pend_r <= KIND_TARE;
                    state_r <= ST_FRAME;
                  end else if (until_poll_r <= 16'd1) begin
                    pend_r <= KIND_READ;
                    state_r <= ST_FRAME;
                  end else begin
                    until_poll_r <= until_poll_r - 16'd1;
                  end
                end
              end
              OP_TARE: begin
                if (!tare_wait_r && pend_r != KIND_TARE) begin
                  acc_r <= 1'b1;
                  if (pend_r == KIND_NONE) begin
                    pend_r  <= KIND_TARE;
                    state_r <= ST_FRAME;
                  end else begin
                    tare_wait_r <= 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        // build request frame, then hash its six bytes
        ST_FRAME: begin
          if (!sent_r) begin
            sent_r <= 1'b1;
            fill_r <= 4'd0;
            since_req_r <= 16'd0;
            frame_r[0] <= dev_addr_r;
            if (pend_r == KIND_READ) begin
              until_poll_r <= poll_int_r;
              frame_r[1] <= FUNC_READ;
              {frame_r[2], frame_r[3]} <= data_reg_r;
              {frame_r[4], frame_r[5]} <= READ_COUNT;
            end else begin
              until_poll_r <= settle_r;
              frame_r[1] <= FUNC_WRITE;
              {frame_r[2], frame_r[3]} <= trig_reg_r;
              {frame_r[4], frame_r[5]} <= tare_cmd_r;
            end
            idx_r <= 4'd0;
            len_r <= 4'd6;
            crc_for_frame_r <= 1'b1;
            state_r <= ST_CRC;
          end else begin
            frame_r[6] <= crc_sts.crc[7:0];
            frame_r[7] <= crc_sts.crc[15:8];
            state_r <= ST_OUT;
          end
        end
        ST_CHECK: begin
          idx_r <= 4'd0;
          len_r <= need - 4'd2;
          crc_for_frame_r <= 1'b0;
          state_r <= ST_CRC;
        end
        ST_CRC: begin
          idx_r <= idx_r + 4'd1;
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (!crc_sts.busy) begin
            if (idx_r == len_r) state_r <= crc_for_frame_r ? ST_FRAME : ST_JUDGE;
            else state_r <= ST_CRC;
          end
        end
        // accept the response or slide the window by one byte
        ST_JUDGE: begin
          if (fields_ok && crc_sts.crc == got_crc) begin
            if (pend_r == KIND_READ) begin
              value_r   <= {win_r[5], win_r[6], win_r[3], win_r[4]};
              have_rd_r <= 1'b1;
              since_rd_r <= 16'd0;
              sample_r  <= 1'b1;
            end else begin
              tdone_r <= 1'b1;
            end
            fill_r <= 4'd0;
            pend_r <= KIND_NONE;
            state_r <= ST_OUT;
          end else begin
            for (int i = 0; i < 8; i++) win_r[i] <= win_r[i + 1];
            fill_r <= fill_r - 4'd1;
            state_r <= (fill_r - 4'd1 >= need) ? ST_CHECK : ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            if (!sent_r || ocnt_r == 3'd7) state_r <= ST_IDLE;
            ocnt_r <= ocnt_r + 3'd1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  logic healthy;
  assign healthy = have_rd_r && (since_rd_r < health_r);

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tlast  = !sent_r || (ocnt_r == 3'd7);
  assign out_tdata  = {8'd0, value_r, sent_r ? frame_r[ocnt_r] : 8'd0};
  assign out_tuser  = {pend_r, healthy, acc_r, tdone_r, sample_r, sent_r};

  // checks
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("ready while busy");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= WIN_DEPTH) else $error("window overfilled");
  a_no_double_tare: assert property (@(posedge clk) disable iff (!rst_n)
    tare_wait_r |-> (pend_r != KIND_TARE))
    else $error("tare queued while a tare is pending");
  a_sample_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && sample_r) |-> (have_rd_r && pend_r == KIND_NONE))
    else $error("sample without reading");

endmodule
